// ----- sv/shuffled_lcg_range_draw_assert.svh -----
// assertion macros shared by the shuffled lcg range draw rtl
`ifndef SHUFFLED_LCG_RANGE_DRAW_ASSERT_SVH
`define SHUFFLED_LCG_RANGE_DRAW_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication check
`define SLRD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("shuffled_lcg_range_draw: check failed");
// next-cycle implication check
`define SLRD_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("shuffled_lcg_range_draw: check failed");
`else
`define SLRD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SLRD_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- sv/slrd_pkg.sv -----
// constants and types shared by the shuffled lcg range draw modules
`default_nettype none
package slrd_pkg;

    // data widths
    localparam int DATA_W = 31;
    localparam int SEED_W = 32;
    localparam int REM_W  = 17;
    localparam int QUO_W  = 15;
    localparam int CNT_W  = 5;

    // minimal standard generator constants (schrage form)
    localparam logic [14:0] LCG_MUL = 15'd16807;
    localparam logic [16:0] LCG_Q   = 17'd127773;
    localparam logic [11:0] LCG_R   = 12'd2836;
    localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;

    // result of one generator step
    typedef struct packed {
        logic               done;
        logic signed [32:0] s;
    } t_step_out;

endpackage
`default_nettype wire

// ----- sv/slrd_step.sv -----
// bit-serial schrage step of the minimal standard generator
`default_nettype none
module slrd_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [slrd_pkg::DATA_W-1:0] i_x,
    output slrd_pkg::t_step_out              o_rsp
);
    import slrd_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_SHIFT, P_MUL} t_phase;

    t_phase             r_phase;
    logic [DATA_W-1:0]  r_sh;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic signed [32:0] r_s;

    logic [REM_W:0]     n_t;
    logic               n_ge;
    logic [REM_W-1:0]   n_rem;
    logic [31:0]        n_p1;
    logic [31:0]        n_p2;

    // one quotient bit of x div q per cycle, msb first
    always_comb begin
        n_t   = {r_rem, r_sh[DATA_W-1]};
        n_ge  = (n_t >= {1'b0, LCG_Q});
        n_rem = n_ge ? REM_W'(n_t - {1'b0, LCG_Q}) : n_t[REM_W-1:0];
    end

    // mul*(x mod q) and r*(x div q)
    assign n_p1 = 32'(r_rem) * 32'(LCG_MUL);
    assign n_p2 = 32'(r_quo) * 32'(LCG_R);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_sh    <= '0;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= '0;
            r_s     <= '0;
        end else if (i_start) begin
            r_phase <= P_SHIFT;
            r_done  <= 1'b0;
            r_sh    <= i_x;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_phase)
                P_IDLE: begin
                    r_done <= 1'b0;
                end
                P_SHIFT: begin
                    r_sh  <= {r_sh[DATA_W-2:0], 1'b0};
                    r_rem <= n_rem;
                    r_quo <= {r_quo[QUO_W-2:0], n_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_s     <= $signed({1'b0, n_p1}) - $signed({1'b0, n_p2});
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.s    = r_s;

endmodule
`default_nettype wire

// ----- sv/slrd_mod.sv -----
// bit-serial remainder by the span, with the shuffle slot residue alongside
`default_nettype none
module slrd_mod #(
    parameter int SHUFFLE_ENTRIES = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [slrd_pkg::DATA_W-1:0]         i_value,
    input  wire logic [slrd_pkg::DATA_W:0]           i_span,
    output logic                                     o_done,
    output logic [slrd_pkg::DATA_W:0]                o_rem,
    output logic [$clog2(SHUFFLE_ENTRIES)-1:0]       o_res
);
    import slrd_pkg::*;

    localparam int          SLOT_W = $clog2(SHUFFLE_ENTRIES);
    localparam logic [SLOT_W:0] ENT_C = (SLOT_W + 1)'(SHUFFLE_ENTRIES);

    logic                r_run;
    logic                r_done;
    logic [DATA_W-1:0]   r_sh;
    logic [DATA_W:0]     r_span;
    logic [DATA_W:0]     r_rem;
    logic [SLOT_W-1:0]   r_res;
    logic [CNT_W-1:0]    r_cnt;

    logic                n_bit;
    logic [DATA_W+1:0]   n_t;
    logic                n_ge;
    logic [SLOT_W:0]     n_u;
    logic                n_uge;

    // restoring step for the span remainder and the slot residue
    always_comb begin
        n_bit = r_sh[DATA_W-1];
        n_t   = {r_rem, n_bit};
        n_ge  = (n_t >= {1'b0, r_span});
        n_u   = {r_res, n_bit};
        n_uge = (n_u >= ENT_C);
    end

    // shift loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_sh   <= '0;
            r_span <= '0;
            r_rem  <= '0;
            r_res  <= '0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_sh   <= i_value;
            r_span <= i_span;
            r_rem  <= '0;
            r_res  <= '0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_sh   <= {r_sh[DATA_W-2:0], 1'b0};
            r_rem  <= n_ge ? (DATA_W + 1)'(n_t - {1'b0, r_span}) : n_t[DATA_W:0];
            r_res  <= n_uge ? SLOT_W'(n_u - ENT_C) : n_u[SLOT_W-1:0];
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ----- sv/shuffled_lcg_range_draw.sv -----
// Park-Miller generator with Bays-Durham shuffle table, drawing a number in a range
// Draw: the bit-serial x div q and value mod span loops run side by side;
//   a new draw can be accepted in the cycle the result shows on o_strobe.
// Reseed: runs WARMUP_STEPS generator steps back to back, then strobes.
// The receiver cannot stall: each result shows for exactly one cycle on o_strobe.
// Synchronous active-low reset clears the generator, slot and the table (valid bits).
`default_nettype none
`include "shuffled_lcg_range_draw_assert.svh"
module shuffled_lcg_range_draw #(
    parameter int SHUFFLE_ENTRIES = 32,
    parameter int WARMUP_STEPS    = 40
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_mode,
    input  wire logic signed [slrd_pkg::SEED_W-1:0] i_seed_value,
    input  wire logic signed [slrd_pkg::DATA_W-1:0] i_range_low,
    input  wire logic signed [slrd_pkg::DATA_W-1:0] i_range_high,
    output logic                                    o_strobe,
    output logic signed [slrd_pkg::DATA_W-1:0]      o_number,
    output logic                                    o_out_of_range
);
    import slrd_pkg::*;

    localparam int SLOT_W = $clog2(SHUFFLE_ENTRIES);
    localparam int WCNT_W = $clog2(WARMUP_STEPS + 1);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_CHK} t_state;

    // control and state
    t_state                     r_state;
    logic                       r_mode;
    logic [DATA_W-1:0]          r_gen;
    logic [SLOT_W-1:0]          r_slot;
    logic [WCNT_W-1:0]          r_cnt;
    logic [SHUFFLE_ENTRIES-1:0] r_valid;
    logic                       r_strobe;
    logic [DATA_W-1:0]          r_num;
    logic                       r_oor;

    // payload
    logic signed [DATA_W-1:0]   r_mn;
    logic signed [DATA_W-1:0]   r_mx;
    logic signed [DATA_W:0]     r_base;
    logic [DATA_W:0]            r_span;
    logic signed [DATA_W:0]     r_sum;
    logic [DATA_W-1:0]          r_rd;
    logic [DATA_W-1:0]          r_tab [SHUFFLE_ENTRIES];

    logic                       w_accept;
    logic [SLOT_W-1:0]          w_ra;
    logic                       w_le;
    logic signed [DATA_W:0]     w_lo;
    logic signed [DATA_W:0]     w_hi;
    logic [DATA_W-1:0]          w_seed;
    logic [DATA_W-1:0]          w_nx;
    logic signed [32:0]         w_fix;
    logic                       w_step_start;
    logic [DATA_W-1:0]          w_step_x;
    logic                       w_last;
    logic                       w_we;
    logic [SLOT_W-1:0]          w_wa;
    logic                       w_oor;
    t_step_out                  w_step;
    logic                       w_mod_done;
    logic [DATA_W:0]            w_mod_rem;
    logic [SLOT_W-1:0]          w_mod_res;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // bounds at full width for base and span, and the seed clamped to at least one
    always_comb begin
        w_lo = {i_range_low[DATA_W-1], i_range_low};
        w_hi = {i_range_high[DATA_W-1], i_range_high};
        w_le = (i_range_low <= i_range_high);
        w_seed = (i_seed_value < 32'sd1) ? DATA_W'(1) : i_seed_value[DATA_W-1:0];
    end

    // step fix-up: draws wrap by the modulus, reseed drops the sign bit
    always_comb begin
        w_fix = w_step.s + $signed({2'b00, LCG_MOD});
        if (!r_mode && w_step.s[32]) begin
            w_nx = w_fix[DATA_W-1:0];
        end else begin
            w_nx = w_step.s[DATA_W-1:0];
        end
    end

    // step unit control
    always_comb begin
        w_last       = (r_cnt == WCNT_W'(1));
        w_step_start = w_accept ||
                       ((r_state == S_RUN) && r_mode && w_step.done && !w_last);
        if (w_accept) begin
            w_step_x = i_mode ? w_seed : r_gen;
        end else begin
            w_step_x = w_nx;
        end
    end

    // table write port
    always_comb begin
        w_we = 1'b0;
        w_wa = r_slot;
        if ((r_state == S_RUN) && w_step.done) begin
            if (r_mode) begin
                w_wa = SLOT_W'(r_cnt);
                w_we = (int'(r_cnt) < SHUFFLE_ENTRIES);
            end else begin
                w_we = 1'b1;
            end
        end
    end

    assign w_ra  = i_mode ? '0 : r_slot;
    assign w_oor = (r_sum < $signed({r_mn[DATA_W-1], r_mn})) ||
                   (r_sum > $signed({r_mx[DATA_W-1], r_mx}));

    // shuffle table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tab[w_wa] <= w_nx;
        end
        if (w_accept) begin
            r_rd <= r_valid[w_ra] ? r_tab[w_ra] : '0;
        end
    end

    // bound registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mn   <= i_range_low;
            r_mx   <= i_range_high;
            r_base <= w_le ? w_lo : w_hi;
            r_span <= (w_le ? (DATA_W + 1)'(w_hi - w_lo) : (DATA_W + 1)'(w_lo - w_hi)) + 1'b1;
        end
    end

    // sequencer with registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 1'b0;
            r_gen    <= '0;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_num    <= '0;
            r_oor    <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (w_we) begin
                r_valid[w_wa] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= i_mode;
                        r_cnt   <= WCNT_W'(WARMUP_STEPS);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_mod_done) begin
                        r_slot <= w_mod_res;
                    end
                    if (r_mode) begin
                        if (w_step.done) begin
                            r_gen <= w_nx;
                            r_cnt <= r_cnt - 1'b1;
                            if (w_last) begin
                                r_strobe <= 1'b1;
                                r_num    <= '0;
                                r_oor    <= 1'b0;
                                r_state  <= S_IDLE;
                            end
                        end
                    end else if (w_step.done) begin
                        r_gen   <= w_nx;
                        r_sum   <= r_base + $signed(w_mod_rem);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_strobe <= 1'b1;
                    r_oor    <= w_oor;
                    r_num    <= w_oor ? r_mn : r_sum[DATA_W-1:0];
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // generator step unit
    slrd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_step_start),
        .i_x     (w_step_x),
        .o_rsp   (w_step)
    );

    // span remainder and slot residue unit
    slrd_mod #(
        .SHUFFLE_ENTRIES (SHUFFLE_ENTRIES)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_value (r_rd),
        .i_span  (r_span),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem),
        .o_res   (w_mod_res)
    );

    assign o_strobe       = r_strobe;
    assign o_number       = r_num;
    assign o_out_of_range = r_oor;

    // checks
    `SLRD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)
    `SLRD_ASSERT_IMP(a_units_aligned, i_clk, i_rst_n, w_mod_done, w_step.done)
    `SLRD_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `SLRD_ASSERT_IMP(a_reseed_zero, i_clk, i_rst_n, o_strobe && r_mode, (o_number == '0) && !o_out_of_range)
    `SLRD_ASSERT_IMP(a_oor_low, i_clk, i_rst_n, o_strobe && o_out_of_range, o_number == r_mn)

endmodule
`default_nettype wire
